// ===== rtl/core/sudf_pkg.sv =====
// sudf_pkg: shared types, codes and the crc-8 byte function of the datagram framer
// no dependencies; used by stepper_uart_datagram_framer
package sudf_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EMIT,
		ST_REPLY
	} state_t;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_WRITE = 2'd0;
	localparam cmd_t CMD_READ  = 2'd1;
	localparam cmd_t CMD_REPLY = 2'd2;

	localparam logic [7:0] CRC_POLY   = 8'h07;
	localparam logic [7:0] SYNC_RESET = 8'h05;
	localparam logic [2:0] WRITE_LAST = 3'd7;
	localparam logic [2:0] READ_LAST  = 3'd3;
	localparam logic [2:0] REPLY_LAST = 3'd7;

	// crc-8, poly 0x07, data taken lsb first
	function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
		logic [7:0] c;
		c = crc;
		for (int i = 0; i < 8; i++) begin
			if (c[7] ^ b[i]) begin
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[6:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

// ===== rtl/core/stepper_uart_datagram_framer.sv =====
// stepper_uart_datagram_framer: request datagram builder and reply collector
// depends on sudf_pkg (state type, command codes, crc-8 byte function)
// sequence: a command transaction moves the sequencer to ST_EMIT, and the first request byte
//   is then registered into the output slot once it is free; one byte per cycle after that
//   while the sink keeps up (8 bytes write, 4 bytes read); s_tready is high only in ST_IDLE,
//   so no command is taken mid-datagram; the single crc-8 byte unit serves one byte per cycle
// reset: arst_n clears the sequencer, the output slot and the reply collector, sync_byte -> 5
module stepper_uart_datagram_framer (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: sync_byte
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// command channel
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,  // node_addr[7:0], reg_addr[14:8], write_data[46:15],
	                              // rx_byte[54:47], zero pad[55]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	// result channel
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,  // tx_byte[7:0], reply_reg[15:8], reply_data[47:16],
	                              // status[48], zero pad[55:49]
	output logic        m_tlast,  // last
	output logic [0:0]  m_tuser   // kind[0]
);

	// unpacked command fields
	logic [1:0]  cmd_in;
	logic [7:0]  addr_in;
	logic [6:0]  reg_in;
	logic [31:0] data_in;
	logic [7:0]  rx_in;

	assign cmd_in  = s_tuser;
	assign addr_in = s_tdata[7:0];
	assign reg_in  = s_tdata[14:8];
	assign data_in = s_tdata[46:15];
	assign rx_in   = s_tdata[54:47];

	// sequencer and latched request
	sudf_pkg::state_t state_q, state_d;
	logic [2:0]  idx_q;
	logic        wr_q;
	logic [7:0]  addr_q;
	logic [6:0]  reg_q;
	logic [31:0] data_q;
	logic [7:0]  rx_q;
	logic [7:0]  txcrc_q;
	logic [7:0]  sync_q;

	// reply collector
	logic [2:0]  count_q;
	logic [7:0]  rcrc_q;
	logic [31:0] rshift_q;
	logic [7:0]  rreg_q;

	// output slot
	logic        ovalid_q;
	logic        okind_q;
	logic [7:0]  otx_q;
	logic        olast_q;
	logic [7:0]  oreg_q;
	logic [31:0] odata_q;
	logic        ostat_q;

	logic       in_acc;
	logic       slot_free;
	logic       emit_fire;
	logic       reply_fire;
	logic [7:0] emit_byte;
	logic [2:0] last_idx;
	logic       emit_last;
	logic [7:0] crc_a;
	logic [7:0] crc_b;
	logic [7:0] crc_y;

	assign cfg_ready = 1'b1;
	assign in_acc    = s_tvalid && s_tready;
	// slot frees up when empty or when its transaction completes this cycle
	assign slot_free = !ovalid_q || m_tready;

	// byte picked for the current position of the datagram
	always_comb begin
		case (idx_q)
			3'd0: emit_byte = sync_q;
			3'd1: emit_byte = addr_q;
			3'd2: emit_byte = {wr_q, reg_q};
			3'd3: emit_byte = wr_q ? data_q[31:24] : txcrc_q;
			3'd4: emit_byte = data_q[23:16];
			3'd5: emit_byte = data_q[15:8];
			3'd6: emit_byte = data_q[7:0];
			default: emit_byte = txcrc_q;
		endcase
	end

	assign last_idx  = wr_q ? sudf_pkg::WRITE_LAST : sudf_pkg::READ_LAST;
	assign emit_last = (idx_q == last_idx);

	// the one crc-8 byte unit, shared by request emission and reply collection
	assign crc_a = (state_q == sudf_pkg::ST_EMIT) ? txcrc_q : rcrc_q;
	assign crc_b = (state_q == sudf_pkg::ST_EMIT) ? emit_byte : rx_in;
	assign crc_y = sudf_pkg::crc8_byte(crc_a, crc_b);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sudf_pkg::ST_IDLE: begin
				if (in_acc) begin
					if (cmd_in == sudf_pkg::CMD_WRITE || cmd_in == sudf_pkg::CMD_READ) begin
						state_d = sudf_pkg::ST_EMIT;
					end else if (cmd_in == sudf_pkg::CMD_REPLY &&
					             count_q == sudf_pkg::REPLY_LAST) begin
						state_d = sudf_pkg::ST_REPLY;
					end
				end
			end
			sudf_pkg::ST_EMIT: begin
				if (slot_free && emit_last) begin
					state_d = sudf_pkg::ST_IDLE;
				end
			end
			sudf_pkg::ST_REPLY: begin
				if (slot_free) begin
					state_d = sudf_pkg::ST_IDLE;
				end
			end
			default: state_d = sudf_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready   = 1'b0;
		emit_fire  = 1'b0;
		reply_fire = 1'b0;
		unique case (state_q)
			sudf_pkg::ST_IDLE:  s_tready   = 1'b1;
			sudf_pkg::ST_EMIT:  emit_fire  = slot_free;
			sudf_pkg::ST_REPLY: reply_fire = slot_free;
			default: s_tready = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sudf_pkg::ST_IDLE;
			idx_q    <= '0;
			sync_q   <= sudf_pkg::SYNC_RESET;
			ovalid_q <= 1'b0;
			count_q  <= '0;
			rcrc_q   <= '0;
			rshift_q <= '0;
			rreg_q   <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				sync_q <= cfg_data;
			end
			if (emit_fire || reply_fire) begin
				ovalid_q <= 1'b1;
			end else if (m_tready) begin
				ovalid_q <= 1'b0;
			end
			if (in_acc) begin
				idx_q <= '0;
			end else if (emit_fire) begin
				idx_q <= idx_q + 3'd1;
			end
			// collector: read request and closing reply both clear it
			if (in_acc && cmd_in == sudf_pkg::CMD_READ) begin
				count_q  <= '0;
				rcrc_q   <= '0;
				rshift_q <= '0;
				rreg_q   <= '0;
			end else if (in_acc && cmd_in == sudf_pkg::CMD_REPLY &&
			             count_q != sudf_pkg::REPLY_LAST) begin
				if (count_q == 3'd2) begin
					rreg_q <= rx_in;
				end
				rcrc_q   <= crc_y;
				rshift_q <= {rshift_q[23:0], rx_in};
				count_q  <= count_q + 3'd1;
			end else if (reply_fire) begin
				count_q  <= '0;
				rcrc_q   <= '0;
				rshift_q <= '0;
				rreg_q   <= '0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_acc) begin
			wr_q    <= (cmd_in == sudf_pkg::CMD_WRITE);
			addr_q  <= addr_in;
			reg_q   <= reg_in;
			data_q  <= data_in;
			rx_q    <= rx_in;
			txcrc_q <= '0;
		end else if (emit_fire) begin
			txcrc_q <= crc_y;
		end
		if (emit_fire) begin
			okind_q <= 1'b0;
			otx_q   <= emit_byte;
			olast_q <= emit_last;
			oreg_q  <= '0;
			odata_q <= '0;
			ostat_q <= 1'b0;
		end else if (reply_fire) begin
			okind_q <= 1'b1;
			otx_q   <= '0;
			olast_q <= 1'b0;
			oreg_q  <= rreg_q;
			odata_q <= rshift_q;
			ostat_q <= (rcrc_q != rx_q);
		end
	end

	assign m_tvalid = ovalid_q;
	assign m_tdata  = {7'd0, ostat_q, odata_q, oreg_q, otx_q};
	assign m_tlast  = olast_q;
	assign m_tuser  = okind_q;

	// a completed reply never carries the datagram end mark
	a_reply_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tlast)
		else $error("reply result marked as last");

	// the closing reply state is entered only with a full collector
	a_reply_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sudf_pkg::ST_REPLY |-> count_q == sudf_pkg::REPLY_LAST)
		else $error("reply emitted before seven bytes were collected");

	// emission never runs past the crc position of its datagram
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sudf_pkg::ST_EMIT |-> idx_q <= last_idx)
		else $error("datagram index past crc byte");

	// a stalled result slot holds its byte while emission waits
	a_emit_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == sudf_pkg::ST_EMIT && m_tvalid && !m_tready |=> $stable(idx_q))
		else $error("datagram advanced while output stalled");

endmodule
